[hdl/irn_pkg.sv]
// Shared types and constants for the interpolation row normaliser.
// Used by the controller, the datapath and the top level; depends on nothing.
package irn_pkg;

   localparam int FRAC_BITS = 15;
   localparam int WEIGHT_W  = 16;
   localparam int SUM_W     = 32;
   localparam int RATIO_W   = 16;
   localparam int DIV_STEPS = FRAC_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   localparam logic [RATIO_W-1:0] ONE_FX   = RATIO_W'(1) << FRAC_BITS;
   localparam logic [SUM_W-1:0]   SUM_MAX  = '1;

   localparam logic REQ_ACCUM = 1'b0;
   localparam logic REQ_EMIT  = 1'b1;

   typedef struct packed {
      logic                req_type;
      logic [WEIGHT_W-1:0] weight;
      logic                col_is_rep;
      logic                col_is_self;
      logic                row_is_rep;
      logic                row_end;
   } irn_req_type;

   typedef struct packed {
      logic [RATIO_W-1:0] ratio;
      logic               zero_sum;
      logic               row_last;
   } irn_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic step;
      logic load;
   } irn_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emits;
      logic needs_div;
      logic out_free;
   } irn_sts_type;

endpackage

[hdl/irn_datapath.sv]
// Datapath of the row normaliser: row sum, restoring divider and output register.
// Depends on irn_pkg.
module irn_datapath (
   input  logic                clock,
   input  logic                reset,
   input  irn_pkg::irn_req_type req_data,
   input  irn_pkg::irn_cmd_type cmd,
   output irn_pkg::irn_sts_type sts,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output irn_pkg::irn_rsp_type rsp_data
);
   import irn_pkg::*;

   logic [SUM_W-1:0]   row_sum_ff, row_sum_in;
   logic [SUM_W-1:0]   div_ff;
   logic [SUM_W-1:0]   rem_ff;
   logic [RATIO_W-1:0] quo_ff;
   logic               zflag_ff;
   logic               last_ff;
   logic               rsp_valid_ff;
   irn_rsp_type        rsp_data_ff;

   logic [SUM_W:0]     sum_wide;
   logic [SUM_W:0]     rem_shift;
   logic               rem_ge;
   logic               sum_zero;
   logic               w_ge_sum;

   assign sum_wide  = {1'b0, row_sum_ff} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, req_data.weight};
   assign sum_zero  = (row_sum_ff == '0);
   assign w_ge_sum  = ({{(SUM_W - WEIGHT_W){1'b0}}, req_data.weight} >= row_sum_ff);
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});

   assign sts.emits     = (req_data.req_type == REQ_EMIT) && req_data.col_is_rep;
   assign sts.needs_div = !req_data.row_is_rep && !sum_zero && !w_ge_sum;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      row_sum_in = row_sum_ff;
      if (cmd.take) begin
         if (req_data.req_type == REQ_ACCUM) begin
            if (req_data.col_is_rep) begin
               row_sum_in = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            end
         end else if (req_data.row_end) begin
            row_sum_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_sum_ff <= '0;
      end else begin
         row_sum_ff <= row_sum_in;
      end
   end

   // Divider and pending result; during a divide the remainder stays below the divisor.
   always_ff @(posedge clock) begin
      if (cmd.take && sts.emits) begin
         last_ff  <= req_data.row_end;
         zflag_ff <= 1'b0;
         div_ff   <= row_sum_ff;
         rem_ff   <= {{(SUM_W - WEIGHT_W){1'b0}}, req_data.weight};
         if (req_data.row_is_rep) begin
            quo_ff <= req_data.col_is_self ? ONE_FX : '0;
         end else if (sum_zero) begin
            quo_ff   <= '0;
            zflag_ff <= 1'b1;
         end else if (w_ge_sum) begin
            quo_ff <= ONE_FX;
         end else begin
            quo_ff <= '0;
         end
      end else if (cmd.step) begin
         if (rem_ge) begin
            rem_ff <= SUM_W'(rem_shift - {1'b0, div_ff});
         end else begin
            rem_ff <= rem_shift[SUM_W-1:0];
         end
         quo_ff <= {quo_ff[RATIO_W-2:0], rem_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff.ratio    <= quo_ff;
         rsp_data_ff.zero_sum <= zflag_ff;
         rsp_data_ff.row_last <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/irn_ctrl.sv]
// Controller of the row normaliser: input handshake and divide sequencing.
// Depends on irn_pkg.
module irn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  irn_pkg::irn_sts_type sts,
   output irn_pkg::irn_cmd_type cmd
);
   import irn_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOAD
   } state_type;

   state_type        state_ff;
   logic             ready_ff;
   logic [CNT_W-1:0] cnt_ff;

   assign cmd.take = req_valid && ready_ff;
   assign cmd.step = (state_ff == ST_DIVIDE);
   assign cmd.load = (state_ff == ST_LOAD) && sts.out_free;
   assign req_ready = ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.take && sts.emits) begin
                  ready_ff <= 1'b0;
                  cnt_ff   <= '0;
                  state_ff <= sts.needs_div ? ST_DIVIDE : ST_LOAD;
               end else begin
                  ready_ff <= 1'b1;
               end
            end
            ST_DIVIDE: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               if (sts.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

[hdl/interpolation_row_normalizer_unit.sv]
// Interpolation row normaliser: one row of a multiscale interpolation matrix.
// Accumulate items and emit items without a result are taken back to back while idle.
// Representative rows, zero sums and weights not below the row sum skip the divider and are loaded directly.
// Other emit items run the 15-step radix-2 divider first; no new item is taken until a result is loaded.
// A result that the receiver holds off keeps the next finished item waiting for the output.
// Synchronous reset clears the row sum, the controller and the output valid.
module interpolation_row_normalizer_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  irn_pkg::irn_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output irn_pkg::irn_rsp_type rsp_data
);
   import irn_pkg::*;

   irn_cmd_type cmd;
   irn_sts_type sts;

   // The controller owns the input handshake and the divide count; the datapath
   // holds the row sum, the divider registers and the output register, so a
   // finished item waits there while the next item is accepted.
   irn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   irn_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // A divide step never coincides with taking a new item.
   a_no_take_during_divide: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take && cmd.step))
      else $error("item taken while divider busy");

   // A result load always shows up as a valid output item.
   a_load_gives_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid)
      else $error("loaded result not presented");

   // An accumulate item never produces a result.
   a_accum_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.req_type == REQ_ACCUM)) |=> !$rose(rsp_valid))
      else $error("accumulate item produced a result");
`endif

endmodule
